[rtl/rld_pkg.sv]
`timescale 1ns / 1ps

package rld_pkg;

    // Field and datapath widths
    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 7;   // holds a count up to 64
    localparam int CALC_W      = 10;  // count * 10 + digit, count <= 64
    localparam int MAX_RUN_DEF = 64;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] ERR_SYMBOL = 8'h00;

    // Controller to datapath
    typedef struct packed {
        logic clr_count;   // clear the count being built
        logic load_digit;  // fold the request's digit into the count
        logic load_run;    // latch symbol and copy count, clear count
        logic dec_run;     // one copy taken downstream
        logic err_out;     // present the error result
    } rld_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic digit;       // request byte is '0'..'9'
        logic space;       // request byte is whitespace
        logic overflow;    // digit would push the count past the limit
        logic zero_count;  // count (after start clear) is zero
        logic last_copy;   // one copy left in the run
    } rld_stat_t;

endpackage

[rtl/run_length_decoder_ascii.sv]
// The first copy of a run is offered the cycle after its symbol request.
// Digit and whitespace requests are taken without output; a symbol with count n
// gives n copies, one per cycle from the run counter while m_axis_tready is high,
// and input waits meanwhile; an error gives one result, a zero-count symbol none.
// Reset (rst_n low, asynchronous): count cleared, parser waits for a count.
`timescale 1ns / 1ps

module run_length_decoder_ascii
    import rld_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tuser,   // [0] stream_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,   // run_last
    output logic              m_axis_tuser    // [0] bad_input
);

    rld_cmd_t  cmd;
    rld_stat_t stat;

    // Parse and emit sequencing
    rld_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .stream_start (s_axis_tuser),
        .in_ready     (s_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Count, symbol and run counter
    rld_datapath #(
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (s_axis_tdata),
        .stream_start (s_axis_tuser),
        .cmd          (cmd),
        .stat         (stat),
        .out_byte     (m_axis_tdata),
        .run_last     (m_axis_tlast),
        .bad_input    (m_axis_tuser)
    );

endmodule

[rtl/rld_datapath.sv]
`timescale 1ns / 1ps

module rld_datapath
    import rld_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              stream_start,
    input  rld_cmd_t          cmd,
    output rld_stat_t         stat,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last,
    output logic              bad_input
);

    logic [RUN_W-1:0]  run_count_reg, run_count_next;
    logic [RUN_W-1:0]  remain_reg, remain_next;
    logic [BYTE_W-1:0] symbol_reg, symbol_next;

    logic [RUN_W-1:0]  count_eff;
    logic [CALC_W-1:0] count_calc;

    // A start-of-stream request sees a cleared count
    assign count_eff = stream_start ? '0 : run_count_reg;

    // count * 10 + digit as shifts and adds
    assign count_calc = CALC_W'({count_eff, 3'b000}) + CALC_W'({count_eff, 1'b0})
                      + CALC_W'(in_byte[3:0]);

    // Byte classification and count checks
    always_comb
    begin
        stat.digit      = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
        stat.space      = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
        stat.overflow   = count_calc > CALC_W'(MAX_RUN);
        stat.zero_count = (count_eff == '0);
        stat.last_copy  = (remain_reg == RUN_W'(1));
    end

    // Next values of count, symbol and copies left
    always_comb
    begin
        run_count_next = run_count_reg;
        remain_next    = remain_reg;
        symbol_next    = symbol_reg;
        if (cmd.clr_count)
        begin
            run_count_next = '0;
        end
        if (cmd.load_digit)
        begin
            run_count_next = count_calc[RUN_W-1:0];
        end
        if (cmd.load_run)
        begin
            symbol_next    = in_byte;
            remain_next    = count_eff;
            run_count_next = '0;
        end
        if (cmd.dec_run)
        begin
            remain_next = remain_reg - RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            run_count_reg <= run_count_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
    end

    // Result fields
    assign out_byte  = cmd.err_out ? ERR_SYMBOL : symbol_reg;
    assign run_last  = cmd.err_out | stat.last_copy;
    assign bad_input = cmd.err_out;

endmodule

[rtl/rld_ctrl.sv]
`timescale 1ns / 1ps

module rld_ctrl
    import rld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      stream_start,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rld_stat_t stat,
    output rld_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_AWAIT,    // waiting for a count
        S_DIGITS,   // inside a count
        S_LOCK,     // error seen, ignore until start
        S_EMIT,     // sending copies of the symbol
        S_ERR_OUT   // sending the error result
    } state_t;

    state_t state_reg, state_next;

    logic locked;
    logic in_digits;

    assign locked    = (state_reg == S_LOCK) && !stream_start;
    assign in_digits = (state_reg == S_DIGITS) && !stream_start;

    // Decode of the request byte against the parse phase
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_AWAIT, S_DIGITS, S_LOCK:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clr_count = stream_start;
                    if (locked)
                    begin
                        state_next = S_LOCK;
                    end
                    else if (stat.digit)
                    begin
                        if (stat.overflow)
                        begin
                            cmd.clr_count = 1'b1;
                            state_next    = S_ERR_OUT;
                        end
                        else
                        begin
                            cmd.load_digit = 1'b1;
                            state_next     = S_DIGITS;
                        end
                    end
                    else if (in_digits)
                    begin
                        // symbol byte: any non-digit
                        if (stat.zero_count)
                        begin
                            cmd.clr_count = 1'b1;
                            state_next    = S_AWAIT;
                        end
                        else
                        begin
                            cmd.load_run = 1'b1;
                            state_next   = S_EMIT;
                        end
                    end
                    else if (stat.space)
                    begin
                        state_next = S_AWAIT;
                    end
                    else
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = S_ERR_OUT;
                    end
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.dec_run = 1'b1;
                    if (stat.last_copy)
                    begin
                        state_next = S_AWAIT;
                    end
                end
            end
            S_ERR_OUT:
            begin
                out_valid   = 1'b1;
                cmd.err_out = 1'b1;
                if (out_ready)
                begin
                    state_next = S_LOCK;
                end
            end
            default:
            begin
                state_next = S_AWAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_AWAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
